// ----- sv/desu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desu_pkg
// shared constants and types for the der ecdsa signature unpacker
// ----------------------------------------------------------------------------
package desu_pkg;

  localparam int unsigned SCALAR_BYTES_DEF = 32;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned ERR_W  = 2;

  localparam logic [BYTE_W-1:0] TAG_SEQUENCE = 8'h30;
  localparam logic [BYTE_W-1:0] TAG_INTEGER  = 8'h02;

  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SEQ_LEN = 3'd1;
  localparam logic [PHASE_W-1:0] PH_INT_TAG = 3'd2;
  localparam logic [PHASE_W-1:0] PH_INT_LEN = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PAD     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DATA    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DONE    = 3'd6;
  localparam logic [PHASE_W-1:0] PH_FAULT   = 3'd7;

  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SEQ_TAG = 2'd1;
  localparam logic [ERR_W-1:0] ERR_INT_TAG = 2'd2;
  localparam logic [ERR_W-1:0] ERR_INT_LEN = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] scalar_byte;
    logic [POS_W-1:0]  byte_position;
    logic [ERR_W-1:0]  error_code;
    logic              last;
  } result_t;

endpackage

// ----- sv/desu_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desu_step
// next-state and result logic for one accepted byte of the der stream
// ----------------------------------------------------------------------------
module desu_step #(
  parameter int unsigned SCALAR_BYTES = desu_pkg::SCALAR_BYTES_DEF,
  parameter int unsigned CNT_W        = $clog2(SCALAR_BYTES)
) (
  input  logic [desu_pkg::PHASE_W-1:0] phase,
  input  logic [CNT_W-1:0]             count,
  input  logic                         second,
  input  logic [desu_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         frame_start,
  output logic [desu_pkg::PHASE_W-1:0] phase_nxt,
  output logic [CNT_W-1:0]             count_nxt,
  output logic                         second_nxt,
  output logic                         emit,
  output desu_pkg::result_t            result
);

  localparam int unsigned POS_SUM_W = desu_pkg::POS_W + 1;

  logic                      end_int;
  logic [POS_SUM_W-1:0]      pos_sum;

  assign end_int = (count == CNT_W'(SCALAR_BYTES - 1));
  assign pos_sum = (second ? POS_SUM_W'(SCALAR_BYTES) : '0) + POS_SUM_W'(count);

  always_comb begin
    phase_nxt  = phase;
    count_nxt  = count;
    second_nxt = second;
    emit       = 1'b0;
    result     = '0;
    if (frame_start) begin
      second_nxt = 1'b0;
      count_nxt  = '0;
      if (data_byte != desu_pkg::TAG_SEQUENCE) begin
        emit              = 1'b1;
        result.error_code = desu_pkg::ERR_SEQ_TAG;
        result.last       = 1'b1;
        phase_nxt         = desu_pkg::PH_FAULT;
      end else begin
        phase_nxt = desu_pkg::PH_SEQ_LEN;
      end
    end else begin
      unique case (phase)
        desu_pkg::PH_SEQ_LEN: begin
          phase_nxt = desu_pkg::PH_INT_TAG;
        end
        desu_pkg::PH_INT_TAG: begin
          if (data_byte != desu_pkg::TAG_INTEGER) begin
            emit              = 1'b1;
            result.error_code = desu_pkg::ERR_INT_TAG;
            result.last       = 1'b1;
            phase_nxt         = desu_pkg::PH_FAULT;
          end else begin
            phase_nxt = desu_pkg::PH_INT_LEN;
          end
        end
        desu_pkg::PH_INT_LEN: begin
          count_nxt = '0;
          priority if (data_byte == desu_pkg::BYTE_W'(SCALAR_BYTES)) begin
            phase_nxt = desu_pkg::PH_DATA;
          end else if (data_byte == desu_pkg::BYTE_W'(SCALAR_BYTES + 1)) begin
            phase_nxt = desu_pkg::PH_PAD;
          end else begin
            emit              = 1'b1;
            result.error_code = desu_pkg::ERR_INT_LEN;
            result.last       = 1'b1;
            phase_nxt         = desu_pkg::PH_FAULT;
          end
        end
        desu_pkg::PH_PAD: begin
          phase_nxt = desu_pkg::PH_DATA;
        end
        desu_pkg::PH_DATA: begin
          emit                 = 1'b1;
          result.scalar_byte   = data_byte;
          result.byte_position = pos_sum[desu_pkg::POS_W-1:0];
          result.error_code    = desu_pkg::ERR_NONE;
          result.last          = end_int && second;
          if (end_int) begin
            count_nxt = '0;
            if (second) begin
              phase_nxt = desu_pkg::PH_DONE;
            end else begin
              second_nxt = 1'b1;
              phase_nxt  = desu_pkg::PH_INT_TAG;
            end
          end else begin
            count_nxt = count + CNT_W'(1);
          end
        end
        default: begin
          // idle, done and fault drop the byte
          phase_nxt = phase;
        end
      endcase
    end
  end

endmodule

// ----- sv/der_ecdsa_signature_unpacker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// der_ecdsa_signature_unpacker
// parses a der ecdsa signature byte stream into numbered raw r/s bytes
// ----------------------------------------------------------------------------
// a result is registered and appears on out_* in the cycle after its byte transfer
// throughput: one byte per cycle while in_tready is high, set by the single parse register stage
// the input stays ready while the output register is empty or being drained
// reset (rst_n low, synchronous) returns the parser to idle, awaiting a
// start-marked byte, and empties the output register
module der_ecdsa_signature_unpacker #(
  parameter int unsigned SCALAR_BYTES = desu_pkg::SCALAR_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] scalar_byte, [13:8] byte_position, [15:14] zero
  output logic [1:0]  out_tuser,  // [1:0] error_code
  output logic        out_tlast
);

  localparam int unsigned CNT_W = $clog2(SCALAR_BYTES);

  logic [desu_pkg::PHASE_W-1:0] phase_r;
  logic [desu_pkg::PHASE_W-1:0] phase_nxt;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic                         second_r;
  logic                         second_nxt;
  logic                         emit;
  desu_pkg::result_t            result_nxt;
  desu_pkg::result_t            result_r;
  logic                         out_valid_r;
  logic                         in_xfer;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  desu_step #(
    .SCALAR_BYTES (SCALAR_BYTES),
    .CNT_W        (CNT_W)
  ) u_step (
    .phase       (phase_r),
    .count       (count_r),
    .second      (second_r),
    .data_byte   (in_tdata),
    .frame_start (in_tuser[0]),
    .phase_nxt   (phase_nxt),
    .count_nxt   (count_nxt),
    .second_nxt  (second_nxt),
    .emit        (emit),
    .result      (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= desu_pkg::PH_IDLE;
      count_r     <= '0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r     <= phase_nxt;
        count_r     <= count_nxt;
        second_r    <= second_nxt;
        out_valid_r <= emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, result_r.byte_position, result_r.scalar_byte};
  assign out_tuser  = result_r.error_code;
  assign out_tlast  = result_r.last;

endmodule
